@@ rtl/core/tsbw_pkg.sv @@
// shared types and constants for the bilinear wrap texture sampler
package tsbw_pkg;

  localparam logic [1:0] CfgWidthLog2  = 2'd0;
  localparam logic [1:0] CfgHeightLog2 = 2'd1;
  localparam logic [1:0] CfgFilterMode = 2'd2;

  localparam logic KindWrite  = 1'b0;
  localparam logic KindSample = 1'b1;

  localparam int unsigned NumTaps = 4;
  localparam int unsigned NumChan = 4;

  typedef logic [16:0] weight_t;
  typedef logic [15:0] level_t;

endpackage

@@ rtl/core/texture_sampler_bilinear_wrap_top.sv @@
// texture sampler top level: texel store, wrap addressing and bilinear blend
//
// channel  | dir | contents
// s_axis   | in  | tuser kind; tdata texel_x, texel_y, texel_color, u_coord, v_coord, active
// m_axis   | out | tdata blue_level, green_level, red_level, alpha_level
// cfg      | in  | width_log2, height_log2, filter_mode by index
//
// one item per cycle while the output register is free or taken
// four banks by x and y parity give four texel reads each cycle
// stages advance together while the output register is free or taken
// reset clears valid bits and config registers only; texels are undefined until written
module texture_sampler_bilinear_wrap_top #(
  parameter int unsigned MAX_SIZE_LOG2 = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic         s_axis_tuser,   // kind
  input  logic [119:0] s_axis_tdata,   // texel_x, texel_y, texel_color, u_coord, v_coord, active
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // blue_level, green_level, red_level, alpha_level
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [3:0]   cfg_wdata_i
);

  localparam int unsigned S = MAX_SIZE_LOG2;
  localparam int unsigned H = (S > 1) ? S - 1 : 1;
  localparam int unsigned BankDepth = 1 << (2 * H);
  localparam int unsigned LW = $clog2(S + 1) > 4 ? $clog2(S + 1) : 4;

  logic [3:0] width_log2_q, height_log2_q;
  logic       filter_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q  <= 4'd8;
      height_log2_q <= 4'd8;
      filter_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsbw_pkg::CfgWidthLog2:  width_log2_q  <= cfg_wdata_i;
        tsbw_pkg::CfgHeightLog2: height_log2_q <= cfg_wdata_i;
        tsbw_pkg::CfgFilterMode: filter_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [LW-1:0] eff_log2(input logic [3:0] r);
    logic [LW-1:0] rr;
    rr = LW'(r);
    if (rr < LW'(1)) return LW'(1);
    if (rr > LW'(S)) return LW'(S);
    return rr;
  endfunction

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic        in_kind, in_act;
  logic [7:0]  in_x, in_y;
  logic [31:0] in_col, in_u, in_v;
  assign in_kind = s_axis_tuser;
  assign in_x    = s_axis_tdata[7:0];
  assign in_y    = s_axis_tdata[15:8];
  assign in_col  = s_axis_tdata[47:16];
  assign in_u    = s_axis_tdata[79:48];
  assign in_v    = s_axis_tdata[111:80];
  assign in_act  = s_axis_tdata[112];

  // stage 1: scale, wrap, fractions, bank write
  logic           v1_q;
  logic [S-1:0]   tx_q, ty_q, tx1_q, ty1_q;
  logic [15:0]    fx_q, fy_q;
  logic           bil1_q;

  logic [47:0]    us, vs;
  logic [S-1:0]   wmask, hmask, tx_d, ty_d;
  logic [LW-1:0]  wl, hl;
  always_comb begin
    wl = eff_log2(width_log2_q);
    hl = eff_log2(height_log2_q);
    us = {16'd0, in_u} << wl;
    vs = {16'd0, in_v} << hl;
    wmask = S'(({{S{1'b0}}, 1'b1} << wl) - 1'b1);
    hmask = S'(({{S{1'b0}}, 1'b1} << hl) - 1'b1);
    tx_d = us[16 +: S] & wmask;
    ty_d = vs[16 +: S] & hmask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid && in_kind == tsbw_pkg::KindSample && in_act;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q   <= tx_d;
      ty_q   <= ty_d;
      tx1_q  <= (tx_d + 1'b1) & wmask;
      ty1_q  <= (ty_d + 1'b1) & hmask;
      fx_q   <= filter_mode_q ? us[15:0] : 16'd0;
      fy_q   <= filter_mode_q ? vs[15:0] : 16'd0;
      bil1_q <= filter_mode_q;
    end
  end

  // four banks by (y parity, x parity)
  logic [31:0] bank0 [BankDepth];
  logic [31:0] bank1 [BankDepth];
  logic [31:0] bank2 [BankDepth];
  logic [31:0] bank3 [BankDepth];

  logic [S-1:0] wx, wy;
  logic         we;
  assign wx = S'(in_x);
  assign wy = S'(in_y);
  assign we = en && s_axis_tvalid && in_kind == tsbw_pkg::KindWrite;

  function automatic logic [2*H-1:0] baddr(input logic [S-1:0] x, input logic [S-1:0] y);
    logic [H-1:0] xh, yh;
    xh = (S > 1) ? H'(x >> 1) : '0;
    yh = (S > 1) ? H'(y >> 1) : '0;
    return {yh, xh};
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) begin
      case ({wy[0], wx[0]})
        2'b00:   bank0[baddr(wx, wy)] <= in_col;
        2'b01:   bank1[baddr(wx, wy)] <= in_col;
        2'b10:   bank2[baddr(wx, wy)] <= in_col;
        default: bank3[baddr(wx, wy)] <= in_col;
      endcase
    end
  end

  // stage 2: bank reads, each bank sees exactly one of the four taps
  logic [S-1:0] xe, xo, ye, yo;
  always_comb begin
    xe = tx_q[0] ? tx1_q : tx_q;
    xo = tx_q[0] ? tx_q  : tx1_q;
    ye = ty_q[0] ? ty1_q : ty_q;
    yo = ty_q[0] ? ty_q  : ty1_q;
  end

  logic        v2_q, sx_q, sy_q;
  logic [31:0] r0_q, r1_q, r2_q, r3_q;
  logic [15:0] fx2_q, fy2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r0_q  <= bank0[baddr(xe, ye)];
      r1_q  <= bank1[baddr(xo, ye)];
      r2_q  <= bank2[baddr(xe, yo)];
      r3_q  <= bank3[baddr(xo, yo)];
      sx_q  <= tx_q[0];
      sy_q  <= ty_q[0];
      fx2_q <= fx_q;
      fy2_q <= fy_q;
    end
  end

  // stage 3: route taps, compute weights
  logic [31:0] t_tl, t_tr, t_bl, t_br, tt0, tt1, tb0, tb1;
  always_comb begin
    tt0 = sy_q ? r2_q : r0_q;
    tt1 = sy_q ? r3_q : r1_q;
    tb0 = sy_q ? r0_q : r2_q;
    tb1 = sy_q ? r1_q : r3_q;
    t_tl = sx_q ? tt1 : tt0;
    t_tr = sx_q ? tt0 : tt1;
    t_bl = sx_q ? tb1 : tb0;
    t_br = sx_q ? tb0 : tb1;
  end

  logic [16:0] cx, cy;
  logic [33:0] p_tl, p_tr, p_bl, p_br;
  assign cx = 17'h10000 - {1'b0, fx2_q};
  assign cy = 17'h10000 - {1'b0, fy2_q};
  assign p_tl = 34'(cy * cx);
  assign p_tr = 34'(cy * {1'b0, fx2_q});
  assign p_bl = 34'({1'b0, fy2_q} * cx);
  assign p_br = 34'({1'b0, fy2_q} * {1'b0, fx2_q});

  logic                  v3_q;
  tsbw_pkg::weight_t     w3_q [tsbw_pkg::NumTaps];
  logic [31:0]           t3_q [tsbw_pkg::NumTaps];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      w3_q[0] <= p_tl[32:16];
      w3_q[1] <= p_tr[32:16];
      w3_q[2] <= p_bl[32:16];
      w3_q[3] <= p_br[32:16];
      t3_q[0] <= t_tl;
      t3_q[1] <= t_tr;
      t3_q[2] <= t_bl;
      t3_q[3] <= t_br;
    end
  end

  // stage 4: per channel products, truncated
  logic       v4_q;
  logic [15:0] pr4_q [tsbw_pkg::NumChan][tsbw_pkg::NumTaps];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < tsbw_pkg::NumChan; c++) begin
        for (int t = 0; t < tsbw_pkg::NumTaps; t++) begin
          pr4_q[c][t] <= 16'((33'({t3_q[t][8*c +: 8], 8'd0}) * 33'(w3_q[t])) >> 16);
        end
      end
    end
  end

  // stage 5: channel sums into the output register
  logic [63:0] out_q;
  logic        ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < tsbw_pkg::NumChan; c++) begin
        out_q[16*c +: 16] <= pr4_q[c][0] + pr4_q[c][1] + pr4_q[c][2] + pr4_q[c][3];
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ test/tb_top.sv @@
// testbench for the bilinear wrap texture sampler: scoreboard with predicted channel levels
class level_board;
  logic [31:0] texels [logic [15:0]];
  logic [3:0]  wl_reg;
  logic [3:0]  hl_reg;
  logic        bilinear;
  logic [63:0] pending_levels [$];
  int          mismatches;

  function void reset_state();
    wl_reg = 4'd8;
    hl_reg = 4'd8;
    bilinear = 1'b0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [3:0] val);
    if (idx == tsbw_pkg::CfgWidthLog2) wl_reg = val;
    else if (idx == tsbw_pkg::CfgHeightLog2) hl_reg = val;
    else if (idx == tsbw_pkg::CfgFilterMode) bilinear = val[0];
  endfunction

  function int clamp_log2(logic [3:0] r);
    if (r < 1) return 1;
    if (r > 8) return 8;
    return r;
  endfunction

  function logic [31:0] texel_at(int x, int y);
    logic [15:0] a;
    a = {y[7:0], x[7:0]};
    if (texels.exists(a)) return texels[a];
    return 32'd0;
  endfunction

  function void note_transfer(logic kind, logic [119:0] d);
    int wl, hl, tx, ty, tx1, ty1;
    logic [47:0] us, vs;
    longint fx, fy, cx, cy, w0, w1, w2, w3, s;
    logic [31:0] t0, t1, t2, t3;
    logic [63:0] lv;
    if (kind == tsbw_pkg::KindWrite) begin
      texels[{d[15:8], d[7:0]}] = d[47:16];
      return;
    end
    if (!d[112]) return;
    wl = clamp_log2(wl_reg);
    hl = clamp_log2(hl_reg);
    us = {16'd0, d[79:48]} << wl;
    vs = {16'd0, d[111:80]} << hl;
    tx = int'((us >> 16) & 48'((1 << wl) - 1));
    ty = int'((vs >> 16) & 48'((1 << hl) - 1));
    t0 = texel_at(tx, ty);
    if (!bilinear) begin
      for (int k = 0; k < 4; k++) lv[16*k +: 16] = {t0[8*k +: 8], 8'd0};
    end else begin
      fx = us[15:0];
      fy = vs[15:0];
      cx = 65536 - fx;
      cy = 65536 - fy;
      w0 = (cy * cx) >> 16;
      w1 = (cy * fx) >> 16;
      w2 = (fy * cx) >> 16;
      w3 = (fy * fx) >> 16;
      tx1 = (tx + 1) & ((1 << wl) - 1);
      ty1 = (ty + 1) & ((1 << hl) - 1);
      t1 = texel_at(tx1, ty);
      t2 = texel_at(tx, ty1);
      t3 = texel_at(tx1, ty1);
      for (int k = 0; k < 4; k++) begin
        s = ((longint'(t0[8*k +: 8]) * 256 * w0) >> 16)
          + ((longint'(t2[8*k +: 8]) * 256 * w2) >> 16)
          + ((longint'(t1[8*k +: 8]) * 256 * w1) >> 16)
          + ((longint'(t3[8*k +: 8]) * 256 * w3) >> 16);
        lv[16*k +: 16] = s[15:0];
      end
    end
    pending_levels.push_back(lv);
  endfunction

  function void check_result(logic [63:0] got);
    logic [63:0] want;
    if (pending_levels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending_levels.pop_front();
    for (int k = 0; k < 4; k++)
      if (got[16*k +: 16] !== want[16*k +: 16]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("channel %0d expected %h got %h", k, want[16*k +: 16], got[16*k +: 16]);
      end
  endfunction
endclass

module tb_top;
  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic         s_axis_tuser = 0;
  logic [119:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [63:0]  m_axis_tdata;
  logic         cfg_we_i = 0;
  logic [1:0]   cfg_idx_i = '0;
  logic [3:0]   cfg_wdata_i = '0;

  level_board board;
  int send_idle_pct, recv_stall_pct;
  longint cycle_count;
  logic [7:0] written_x [$];
  logic [7:0] written_y [$];

  texture_sampler_bilinear_wrap_top dut (.*);

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);

  always @(negedge clk_i)
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);

  // valid stays up after a transfer until the next item or a drain decides
  task automatic send_item(logic kind, logic [119:0] d);
    while (($urandom_range(99) < send_idle_pct)) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_transfer(kind, d);
    @(negedge clk_i);
  endtask

  task automatic write_texel(logic [7:0] x, logic [7:0] y, logic [31:0] c);
    send_item(tsbw_pkg::KindWrite,
              {7'd0, 1'($urandom_range(1)), $urandom(), $urandom(), c, y, x});
    written_x.push_back(x);
    written_y.push_back(y);
  endtask

  task automatic sample(logic [31:0] u, logic [31:0] v, logic act);
    send_item(tsbw_pkg::KindSample, {7'd0, act, v, u, $urandom(), 16'($urandom())});
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending_levels.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [3:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    board.set_reg(idx, val);
  endtask

  task automatic fill_texture(int wl, int hl);
    for (int y = 0; y < (1 << hl); y++)
      for (int x = 0; x < (1 << wl); x++)
        write_texel(8'(x), 8'(y), $urandom());
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++)
      if ($urandom_range(9) == 0) write_texel(written_x[0], written_y[0], $urandom());
      else case ($urandom_range(3))
        0: sample($urandom(), $urandom(), $urandom_range(7) != 0);
        1: sample($urandom_range(65535) | (32'($urandom_range(3)) << 16),
                  $urandom_range(65535), 1);
        2: sample({$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom())},
                  {16'($urandom()), $urandom_range(1) ? 16'hffff : 16'h0}, 1);
        default: sample($urandom(), $urandom(), 1);
      endcase
  endtask

  initial begin
    board = new();
    board.reset_state();
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // small texture filled completely, extremes of fields and sizes
    set_reg(tsbw_pkg::CfgWidthLog2, 4'd2);
    set_reg(tsbw_pkg::CfgHeightLog2, 4'd1);
    set_reg(tsbw_pkg::CfgFilterMode, 1'b1);
    fill_texture(2, 1);
    write_texel(8'hff, 8'hff, 32'hffff_ffff);
    write_texel(8'h00, 8'h00, 32'h0000_0000);
    write_texel(8'h01, 8'h00, 32'hffff_ffff);
    sample(32'h0, 32'h0, 1);
    sample(32'hffff_ffff, 32'hffff_ffff, 1);
    sample(32'h0000_8000, 32'h0000_8000, 1);
    sample(32'h1234_5678, 32'h8765_4321, 0);
    sample(32'h0001_0000, 32'h0003_c000, 1);
    drain();
    set_reg(tsbw_pkg::CfgFilterMode, 1'b0);
    sample(32'hffff_ffff, 32'h0, 1);
    sample(32'h0000_4000, 32'h0000_ffff, 1);
    drain();
    // register values outside the legal range clamp to one and eight
    set_reg(tsbw_pkg::CfgWidthLog2, 4'd0);
    set_reg(tsbw_pkg::CfgHeightLog2, 4'd0);
    sample(32'hffff_ffff, 32'h0000_8000, 1);
    drain();
    set_reg(tsbw_pkg::CfgFilterMode, 1'b1);
    sample(32'h0000_c000, 32'h7fff_ffff, 1);
    drain();
    for (int w = 1; w <= 8; w += 7) begin
      set_reg(tsbw_pkg::CfgWidthLog2, 4'd1);
      set_reg(tsbw_pkg::CfgHeightLog2, w == 8 ? 4'd15 : 4'd1);
      if (w == 8) begin
        send_idle_pct = 0;
        fill_texture(1, 8);
      end
      random_phase(80, 0, 0);
      random_phase(80, 87, 0);
      drain();
      set_reg(tsbw_pkg::CfgFilterMode, 1'b0);
      random_phase(80, 0, 87);
      random_phase(80, 27, 27);
      drain();
      set_reg(tsbw_pkg::CfgFilterMode, 1'b1);
    end
    set_reg(tsbw_pkg::CfgWidthLog2, 4'd2);
    set_reg(tsbw_pkg::CfgHeightLog2, 4'd1);
    random_phase(30, 27, 27);
    drain();
    if (board.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
